// ----- rtl/crc16fc_pkg.sv -----
`timescale 1ns / 1ps
package crc16fc_pkg;

   localparam logic [7:0]  START_BYTE_RESET = 8'd35;
   localparam logic [15:0] EXP_LEN_RESET    = 16'd113;

   localparam logic        CSR_START_BYTE = 1'b0;
   localparam logic        CSR_EXP_LEN    = 1'b1;

   localparam logic        KIND_PAYLOAD = 1'b0;
   localparam logic        KIND_VERDICT = 1'b1;

   localparam logic [2:0]  ST_OK        = 3'd0;
   localparam logic [2:0]  ST_BAD_START = 3'd1;
   localparam logic [2:0]  ST_BAD_LEN   = 3'd2;
   localparam logic [2:0]  ST_CRC_BAD   = 3'd3;
   localparam logic [2:0]  ST_TRUNCATED = 3'd4;

   localparam int          FIFO_DEPTH = 4;
   localparam int          FIFO_AW    = 2;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [2:0]  status;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
      logic        last;
   } result_type;

   // CRC-16/XMODEM, one byte, poly 0x1021
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, b};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {c[10:0], 5'b00000} & 16'h1fe0;
      return c;
   endfunction

   function automatic result_type verdict(input logic [2:0] st, input logic [15:0] cc,
                                          input logic [15:0] rc, input logic last);
      result_type r;
      r.kind         = KIND_VERDICT;
      r.payload_byte = 8'h00;
      r.byte_index   = 16'h0000;
      r.status       = st;
      r.computed_crc = cc;
      r.received_crc = rc;
      r.last         = last;
      return r;
   endfunction

endpackage

// ----- rtl/crc16fc_step.sv -----
`timescale 1ns / 1ps
module crc16fc_step #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              byte_value,
   input  logic                    chunk_start,
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [15:0]             csr_wdata,
   output logic [1:0]              push_count,
   output crc16fc_pkg::result_type res0,
   output crc16fc_pkg::result_type res1
);
   import crc16fc_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_LEN_LO  = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC_LO  = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;

   localparam logic [15:0] LEN_MASK = 16'((32'h1 << LENGTH_BITS) - 32'h1);

   logic [7:0]  start_byte_ff, start_byte_in;
   logic [15:0] exp_len_ff, exp_len_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_ff, held_in;

   logic [15:0] word;
   logic [15:0] crc_next;
   logic [15:0] count_next;
   logic        mid_frame;

   assign word       = {byte_value, held_ff};
   assign crc_next   = crc_byte(crc_ff, byte_value);
   assign count_next = count_ff + 16'd1;
   assign mid_frame  = (phase_ff >= PH_LEN_LO) && (phase_ff <= PH_CRC_HI);

   always_comb begin
      start_byte_in = start_byte_ff;
      exp_len_in    = exp_len_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_START_BYTE: start_byte_in = csr_wdata[7:0];
            CSR_EXP_LEN:    exp_len_in    = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      held_in    = held_ff;
      res0       = '0;
      res1       = '0;
      push_count = 2'd0;
      if (chunk_start) begin
         count_in = 16'h0000;
         crc_in   = 16'h0000;
         if (mid_frame) begin
            res0       = verdict(ST_TRUNCATED, crc_ff, 16'h0000, 1'b1);
            push_count = 2'd1;
         end
         if (byte_value == start_byte_ff) begin
            phase_in = PH_LEN_LO;
         end else begin
            phase_in = PH_IDLE;
            if (mid_frame) begin
               res0.last  = 1'b0;
               res1       = verdict(ST_BAD_START, 16'h0000, 16'h0000, 1'b1);
               push_count = 2'd2;
            end else begin
               res0       = verdict(ST_BAD_START, 16'h0000, 16'h0000, 1'b1);
               push_count = 2'd1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               held_in  = byte_value;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if ((word != exp_len_ff) || ((word & ~LEN_MASK) != 16'h0000)) begin
                  phase_in   = PH_IDLE;
                  res0       = verdict(ST_BAD_LEN, 16'h0000, 16'h0000, 1'b1);
                  push_count = 2'd1;
               end else begin
                  count_in = 16'h0000;
                  crc_in   = 16'h0000;
                  phase_in = (word == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in            = crc_next;
               count_in          = count_next;
               res0.kind         = KIND_PAYLOAD;
               res0.payload_byte = byte_value;
               res0.byte_index   = count_ff;
               res0.status       = ST_OK;
               res0.computed_crc = crc_next;
               res0.received_crc = 16'h0000;
               res0.last         = 1'b1;
               push_count        = 2'd1;
               if ((count_next == exp_len_ff) || (count_next == 16'h0000)) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               held_in  = byte_value;
               phase_in = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               res0       = verdict((word == crc_ff) ? ST_OK : ST_CRC_BAD, crc_ff, word, 1'b1);
               push_count = 2'd1;
               phase_in   = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         exp_len_ff    <= EXP_LEN_RESET;
         phase_ff      <= PH_IDLE;
         count_ff      <= 16'h0000;
         crc_ff        <= 16'h0000;
         held_ff       <= 8'h00;
      end else begin
         start_byte_ff <= start_byte_in;
         exp_len_ff    <= exp_len_in;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            crc_ff   <= crc_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

// ----- rtl/crc16fc_fifo.sv -----
`timescale 1ns / 1ps
module crc16fc_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  crc16fc_pkg::result_type push0,
   input  crc16fc_pkg::result_type push1,
   input  logic                    pop,
   output logic                    room2,
   output logic                    not_empty,
   output crc16fc_pkg::result_type head
);
   import crc16fc_pkg::*;

   result_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 do_pop;

   assign not_empty = (cnt_ff != '0);
   assign room2     = (cnt_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
   assign head      = mem_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff + FIFO_AW'(push_count);
      rd_in  = rd_ff + FIFO_AW'(do_pop);
      cnt_in = cnt_ff + (FIFO_AW + 1)'(push_count) - (FIFO_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + FIFO_AW'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/crc16_frame_checker.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                                   tuser        tlast
// req_      in         byte_value[7:0]                                      chunk_start  -
// rsp_      out        payload_byte, byte_index, status, computed_crc,      kind         last_of_run
//                      received_crc, zero pad to 64 bits
// csr_      in         csr_addr 0 start_byte, 1 expected_length             -            -
//
// One request per cycle while req_tready is high; its results land in a four-entry output queue the next cycle.
// A request that opens a chunk mid-frame with a wrong opener yields two results.
// req_tready is high while the queue has room for two results.
// Reset is synchronous; it empties the queue and returns the framer to idle.
module crc16_frame_checker #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic [0:0]  req_tuser,   // chunk_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // payload_byte, byte_index, status, computed_crc, received_crc
   output logic [0:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import crc16fc_pkg::*;

   logic       accept;
   logic [1:0] push_cnt;
   logic [1:0] push_cnt_gated;
   result_type res0;
   result_type res1;
   result_type head;

   assign accept         = req_tvalid && req_tready;
   assign push_cnt_gated = accept ? push_cnt : 2'd0;

   crc16fc_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_tdata),
      .chunk_start(req_tuser[0]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .push_count (push_cnt),
      .res0       (res0),
      .res1       (res1)
   );

   crc16fc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_count(push_cnt_gated),
      .push0     (res0),
      .push1     (res1),
      .pop       (rsp_tready),
      .room2     (req_tready),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {5'b00000, head.received_crc, head.computed_crc, head.status,
                       head.byte_index, head.payload_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
